/* design/assert_macros.svh */
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbs assertion failed");

// next-cycle implication, disabled in reset
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbs assertion failed");

`endif

/* design/rbs_pkg.sv */
// types and constants of the refresh backoff scheduler
package rbs_pkg;

  localparam int REG_W               = 17;
  localparam int CNT_W               = 10;
  localparam int NOW_W               = 32;
  localparam int CFG_IDX_W           = 3;
  localparam int TIME_BITS_DEF       = 32;
  localparam int FAILURE_LIMIT_DEF   = 1000;
  localparam int BACKOFF_SHIFT_LIMIT = 8;
  localparam int IN_TDATA_W          = 40;
  localparam int IN_TUSER_W          = 2;
  localparam int OUT_TDATA_W         = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_MAX  = 3'd4;

  localparam logic [REG_W-1:0] MIN_GAP_RST    = 17'd60;
  localparam logic [REG_W-1:0] INTERVAL_RST   = 17'd3600;
  localparam logic [REG_W-1:0] STALE_RST      = 17'd1800;
  localparam logic [REG_W-1:0] RETRY_BASE_RST = 17'd60;
  localparam logic [REG_W-1:0] RETRY_MAX_RST  = 17'd1800;

  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_ATTEMPT = 2'd1,
    REQ_SUCCESS = 2'd2,
    REQ_FAILURE = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [REG_W-1:0] min_request_gap;
    logic [REG_W-1:0] refresh_interval;
    logic [REG_W-1:0] stale_on_launch;
    logic [REG_W-1:0] retry_base_delay;
    logic [REG_W-1:0] retry_max_delay;
  } rbs_cfg_t;

  typedef struct packed {
    logic             should_request;
    logic             should_request_on_launch;
    logic [REG_W-1:0] retry_delay;
    logic [CNT_W-1:0] failure_count;
  } rbs_res_t;

endpackage

/* design/rbs_cfg_regs.sv */
// configuration register file
module rbs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbs_pkg::REG_W-1:0]     cfg_data,
  output rbs_pkg::rbs_cfg_t             cfg
);
  import rbs_pkg::*;

  rbs_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_request_gap  <= MIN_GAP_RST;
      cfg_r.refresh_interval <= INTERVAL_RST;
      cfg_r.stale_on_launch  <= STALE_RST;
      cfg_r.retry_base_delay <= RETRY_BASE_RST;
      cfg_r.retry_max_delay  <= RETRY_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_GAP:    cfg_r.min_request_gap  <= cfg_data;
        CFG_INTERVAL:   cfg_r.refresh_interval <= cfg_data;
        CFG_STALE:      cfg_r.stale_on_launch  <= cfg_data;
        CFG_RETRY_BASE: cfg_r.retry_base_delay <= cfg_data;
        CFG_RETRY_MAX:  cfg_r.retry_max_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* design/rbs_eval.sv */
// scheduler state and the per-item decision logic
module rbs_eval #(
  parameter int TIME_BITS     = rbs_pkg::TIME_BITS_DEF,
  parameter int FAILURE_LIMIT = rbs_pkg::FAILURE_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rbs_pkg::rbs_cfg_t         cfg,
  input  logic                      fire,
  input  rbs_pkg::req_type_t        req_type,
  input  logic [rbs_pkg::NOW_W-1:0] now,
  input  logic                      link_connected,
  output rbs_pkg::rbs_res_t         res
);
  import rbs_pkg::*;

  `include "assert_macros.svh"

  localparam int EW = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;
  localparam int SH_W = REG_W + BACKOFF_SHIFT_LIMIT - 1;

  logic [TIME_BITS-1:0] last_attempt_r, last_attempt_nxt;
  logic [TIME_BITS-1:0] last_success_r, last_success_nxt;
  logic [CNT_W-1:0]     fail_cnt_r, fail_cnt_nxt;

  logic [TIME_BITS-1:0] now_w;
  logic [3:0]           cnt_m1;
  logic [SH_W-1:0]      shifted;
  logic [REG_W-1:0]     delay;
  logic                 gap_ok;
  logic                 due;
  logic                 due_launch;

  function automatic logic elapsed(input logic [TIME_BITS-1:0] now_v,
                                   input logic [TIME_BITS-1:0] since_v,
                                   input logic [REG_W-1:0]     secs);
    logic [EW-1:0] diff;
    diff = EW'(now_v - since_v);
    return (since_v == '0) || (now_v < since_v) || (diff >= EW'(secs));
  endfunction

  assign now_w   = TIME_BITS'(now);
  assign cnt_m1  = fail_cnt_r[3:0] - 4'd1;
  assign shifted = SH_W'(cfg.retry_base_delay) << cnt_m1[2:0];

  // backoff delay for the current failure count
  always_comb begin
    if (fail_cnt_r == '0) begin
      delay = cfg.retry_base_delay;
    end else if (fail_cnt_r > CNT_W'(BACKOFF_SHIFT_LIMIT)) begin
      delay = cfg.retry_max_delay;
    end else if (shifted > SH_W'(cfg.retry_max_delay)) begin
      delay = cfg.retry_max_delay;
    end else begin
      delay = shifted[REG_W-1:0];
    end
  end

  always_comb begin
    gap_ok = elapsed(now_w, last_attempt_r, cfg.min_request_gap);
    if (!gap_ok) begin
      due = 1'b0;
    end else if (fail_cnt_r != '0) begin
      due = elapsed(now_w, last_attempt_r, delay);
    end else begin
      due = elapsed(now_w, last_success_r, cfg.refresh_interval);
    end
    due_launch = gap_ok && elapsed(now_w, last_success_r, cfg.stale_on_launch);
  end

  assign res.should_request           = link_connected && due;
  assign res.should_request_on_launch = link_connected && due_launch;
  assign res.retry_delay              = delay;
  assign res.failure_count            = fail_cnt_r;

  always_comb begin
    last_attempt_nxt = last_attempt_r;
    last_success_nxt = last_success_r;
    fail_cnt_nxt     = fail_cnt_r;
    unique case (req_type)
      REQ_NONE: ;
      REQ_ATTEMPT: last_attempt_nxt = now_w;
      REQ_SUCCESS: begin
        last_success_nxt = now_w;
        fail_cnt_nxt     = '0;
      end
      REQ_FAILURE: begin
        last_attempt_nxt = now_w;
        if (fail_cnt_r < CNT_W'(FAILURE_LIMIT)) begin
          fail_cnt_nxt = fail_cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_attempt_r <= '0;
      last_success_r <= '0;
      fail_cnt_r     <= '0;
    end else if (fire) begin
      last_attempt_r <= last_attempt_nxt;
      last_success_r <= last_success_nxt;
      fail_cnt_r     <= fail_cnt_nxt;
    end
  end

  `RBS_ASSERT_NOW(a_cnt_limit, clk, rst_n, 1'b1, fail_cnt_r <= CNT_W'(FAILURE_LIMIT))
  `RBS_ASSERT_NEXT(a_success_clears, clk, rst_n, fire && req_type == REQ_SUCCESS, fail_cnt_r == '0)
  `RBS_ASSERT_NOW(a_delay_capped, clk, rst_n, fail_cnt_r != '0, delay <= cfg.retry_max_delay)

endmodule

/* design/refresh_backoff_scheduler_core.sv */
// refresh backoff scheduler top level with input and result registers
// An item enters the input register when accepted; once the result register is
// free, the decision is worked out from the scheduler state in one pass and
// written to the result register, while the item's event updates the state at
// the same edge. One item is taken every clock while the result side keeps
// up. Configuration writes are taken at any time with cfg_ready held high and
// act from the next cycle.
module refresh_backoff_scheduler_core #(
  parameter int TIME_BITS     = rbs_pkg::TIME_BITS_DEF,
  parameter int FAILURE_LIMIT = rbs_pkg::FAILURE_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // now [31:0], link_connected [32], zero [39:33]
  input  logic [rbs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type [1:0]
  input  logic [rbs_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // should_request [0], should_request_on_launch [1], retry_delay [18:2],
  // failure_count [28:19], zero [31:29]
  output logic [rbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbs_pkg::REG_W-1:0]       cfg_data
);
  import rbs_pkg::*;

  `include "assert_macros.svh"

  localparam int RES_W = REG_W + CNT_W + 2;

  rbs_cfg_t           cfg;
  rbs_res_t           res;
  logic               s1_vld_r;
  req_type_t          s1_type_r;
  logic [NOW_W-1:0]   s1_now_r;
  logic               s1_link_r;
  logic               out_vld_r;
  logic [RES_W-1:0]   out_res_r;
  logic               out_free;
  logic               s1_move;
  logic               in_take;

  assign out_free  = !out_vld_r || out_tready;
  assign s1_move   = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  rbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbs_eval #(
    .TIME_BITS     (TIME_BITS),
    .FAILURE_LIMIT (FAILURE_LIMIT)
  ) u_eval (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .fire           (s1_move),
    .req_type       (s1_type_r),
    .now            (s1_now_r),
    .link_connected (s1_link_r),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_vld_r <= 1'b1;
      end else if (s1_move) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_move) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_type_r <= req_type_t'(in_tuser[1:0]);
      s1_now_r  <= in_tdata[NOW_W-1:0];
      s1_link_r <= in_tdata[NOW_W];
    end
    if (s1_move) begin
      out_res_r <= {res.failure_count, res.retry_delay,
                    res.should_request_on_launch, res.should_request};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_res_r};

  `RBS_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, s1_vld_r && out_vld_r && !out_tready, !in_tready)
  `RBS_ASSERT_NEXT(a_take_fills_s1, clk, rst_n, in_take, s1_vld_r)
  `RBS_ASSERT_NEXT(a_move_fills_out, clk, rst_n, s1_move, out_vld_r)

endmodule
